// ===== sv/md5_stream_hash_top_assert.svh =====
// Assertion macros for the MD5 stream hash block.
`ifndef MD5_STREAM_HASH_TOP_ASSERT_SVH
`define MD5_STREAM_HASH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MSH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MSH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MSH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/msh_pkg.sv =====
// Shared types, constants and step functions of the MD5 stream hash block.
package msh_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  // Word passed from the intake to the engine
  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } msh_word_t;

  function automatic logic [31:0] step_const(input logic [5:0] n);
    logic [31:0] k;
    begin
      case (n)
        6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
        6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
        6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
        6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
        default: k = 32'h0;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] n);
    logic [4:0] s;
    begin
      case ({n[5:4], n[1:0]})
        4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
        4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
        4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
        4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; 4'hf: s = 5'd21;
        default: s = 5'd0;
      endcase
      return s;
    end
  endfunction

  // Message word index used by step n
  function automatic logic [3:0] word_sel(input logic [5:0] n);
    logic [3:0] g;
    begin
      case (n[5:4])
        2'd0: g = n[3:0];
        2'd1: g = 4'(5 * n[3:0] + 1);
        2'd2: g = 4'(3 * n[3:0] + 5);
        default: g = 4'(7 * n[3:0]);
      endcase
      return g;
    end
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] d;
    begin
      d = {x, x} << s;
      return d[63:32];
    end
  endfunction

  function automatic logic [31:0] bswap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ===== sv/msh_queue.sv =====
// Two-entry queue of words between the intake and the engine.
module msh_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  msh_pkg::msh_word_t wr_word,
  output logic              rd_valid,
  input  logic              rd_ready,
  output msh_pkg::msh_word_t rd_word
);
  localparam int unsigned AW = $clog2(msh_pkg::QUEUE_DEPTH);

  msh_pkg::msh_word_t mem_r [msh_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push, pop;

  assign wr_ready = (cnt_r != (AW+1)'(msh_pkg::QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_word  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_word;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== sv/msh_intake.sv =====
// Input stage: registers one word and offers it to the queue.
module msh_intake (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              flush,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [7:0]        in_data_byte,
  output logic              q_valid,
  input  logic              q_ready,
  output msh_pkg::msh_word_t q_word
);
  logic               hold_r;
  msh_pkg::msh_word_t word_r;

  assign in_ready = !hold_r || q_ready;
  assign q_valid  = hold_r;
  assign q_word   = word_r;

  // Capture the word and classify it (absorb or finish)
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      hold_r <= 1'b0;
    end else if (in_ready) begin
      hold_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r.func <= in_func;
      word_r.data <= (in_func == msh_pkg::FUNC_FINISH) ? msh_pkg::PAD_MARK : in_data_byte;
    end
  end
endmodule

// ===== sv/msh_engine.sv =====
// Back end: block buffer, padding and the 64-step compression loop.
module msh_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       seed,
  input  logic              restart,
  input  logic              w_valid,
  output logic              w_ready,
  input  msh_pkg::msh_word_t w_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_digest_first,
  output logic [63:0]       out_digest_second
);
  typedef enum logic [2:0] {
    S_TAKE, S_PAD, S_LEN, S_RUN, S_FOLD, S_EMIT
  } state_t;

  state_t state_r;
  logic [31:0] chain_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] wbuf_r [16];
  logic [63:0] bits_r;
  logic [5:0]  idx_r, step_r;
  logic        fin_r, last_r;
  logic        ovalid_r;
  logic [63:0] dig0_r, dig1_r;

  logic [31:0] f, t, wsel, newb;
  logic [31:0] init [4];

  assign init[0] = msh_pkg::INIT_A + seed * 32'd11;
  assign init[1] = msh_pkg::INIT_B + seed * 32'd71;
  assign init[2] = msh_pkg::INIT_C + seed * 32'd37;
  assign init[3] = msh_pkg::INIT_D + seed * 32'd97;

  assign w_ready = (state_r == S_TAKE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_digest_first = dig0_r;
  assign out_digest_second = dig1_r;

  // Round function of the current step
  always_comb begin
    case (step_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    wsel = wbuf_r[msh_pkg::word_sel(step_r)];
    t = a_r + f + msh_pkg::step_const(step_r) + wsel;
    newb = b_r + msh_pkg::rotl(t, msh_pkg::rot_amount(step_r));
  end

  // Sequence intake, padding, compression and result
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r <= S_TAKE;
      bits_r <= '0;
      idx_r <= '0;
      fin_r <= 1'b0;
      last_r <= 1'b0;
      ovalid_r <= 1'b0;
      step_r <= '0;
      for (int i = 0; i < 4; i++) chain_r[i] <= init[i];
    end else begin
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      case (state_r)
        S_TAKE: begin
          if (w_valid && w_ready) begin
            wbuf_r[idx_r[5:2]][8*idx_r[1:0] +: 8] <= w_word.data;
            idx_r <= idx_r + 6'd1;
            if (w_word.func == msh_pkg::FUNC_FINISH) begin
              fin_r <= 1'b1;
              // pad mark in the last byte fills the block: compress it at once
              if (idx_r == 6'd63) begin
                last_r <= 1'b0;
                state_r <= S_RUN;
                {a_r, b_r, c_r, d_r} <= {chain_r[0], chain_r[1], chain_r[2], chain_r[3]};
              end else begin
                state_r <= S_PAD;
              end
            end else begin
              bits_r <= bits_r + 64'd8;
              if (idx_r == 6'd63) begin
                last_r <= 1'b0;
                state_r <= S_RUN;
                {a_r, b_r, c_r, d_r} <= {chain_r[0], chain_r[1], chain_r[2], chain_r[3]};
              end
            end
          end
        end
        S_PAD: begin
          // zero-fill one byte a cycle up to the length field or block end
          if (idx_r == 6'd56 && !last_r) begin
            state_r <= S_LEN;
          end else begin
            wbuf_r[idx_r[5:2]][8*idx_r[1:0] +: 8] <= 8'h00;
            idx_r <= idx_r + 6'd1;
            if (idx_r == 6'd63) begin
              state_r <= S_RUN;
              {a_r, b_r, c_r, d_r} <= {chain_r[0], chain_r[1], chain_r[2], chain_r[3]};
            end
          end
        end
        S_LEN: begin
          wbuf_r[14] <= bits_r[31:0];
          wbuf_r[15] <= bits_r[63:32];
          last_r <= 1'b1;
          state_r <= S_RUN;
          {a_r, b_r, c_r, d_r} <= {chain_r[0], chain_r[1], chain_r[2], chain_r[3]};
        end
        S_RUN: begin
          a_r <= d_r;
          d_r <= c_r;
          c_r <= b_r;
          b_r <= newb;
          step_r <= step_r + 6'd1;
          if (step_r == 6'd63) state_r <= S_FOLD;
        end
        S_FOLD: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          if (!fin_r) state_r <= S_TAKE;
          else if (last_r) state_r <= S_EMIT;
          else state_r <= S_PAD;
        end
        S_EMIT: begin
          if (!ovalid_r) begin
            ovalid_r <= 1'b1;
            dig0_r <= {msh_pkg::bswap(chain_r[0]), msh_pkg::bswap(chain_r[1])};
            dig1_r <= {msh_pkg::bswap(chain_r[2]), msh_pkg::bswap(chain_r[3])};
            for (int i = 0; i < 4; i++) chain_r[i] <= init[i];
            bits_r <= '0;
            idx_r <= '0;
            fin_r <= 1'b0;
            last_r <= 1'b0;
            state_r <= S_TAKE;
          end
        end
        default: state_r <= S_TAKE;
      endcase
    end
  end
endmodule

// ===== sv/md5_stream_hash_top.sv =====
// Top level of the streaming MD5 digest block.
// Channels: in_valid/in_ready carry one word per item: in_func 0 absorbs
// in_data_byte, in_func 1 finishes the message. out_valid/out_ready carry
// the 16-byte digest as out_digest_first and out_digest_second.
// cfg_we with cfg_seed_offset sets the seed (0 gives plain MD5) and
// restarts the message at once; write it only while idle.
// Every 64th byte starts a 64-step compression run and a fold, one step
// per cycle in a single round unit; the engine takes no bytes meanwhile.
// On a finish the engine zero-fills up to the length field, writes the
// length and runs the final compression (with an extra fill and an extra
// run when the pad mark lands past byte 55), then loads the digest register.
// A two-word queue sits between the intake register and the engine, so
// the sender keeps going while the engine compresses or the result waits,
// until the queue and the intake register are full.
// A stalled receiver holds the digest; the engine waits before the next
// block until the digest is taken.
// Reset (rst_n low, synchronous) clears the seed, the count, the queue and the intake register.
module md5_stream_hash_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_first,
  output logic [63:0] out_digest_second,
  input  logic        cfg_we,
  input  logic [31:0] cfg_seed_offset
);
  `include "md5_stream_hash_top_assert.svh"

  logic [31:0] seed_r;
  logic [31:0] seed_eff;
  logic        iq_valid, iq_ready, qe_valid, qe_ready;
  msh_pkg::msh_word_t iq_word, qe_word;

  // Hold the seed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      seed_r <= cfg_seed_offset;
    end
  end

  // Start from a zero seed in reset, from the new seed on a write
  assign seed_eff = !rst_n ? 32'h0 : (cfg_we ? cfg_seed_offset : seed_r);

  msh_intake u_intake (
    .clk, .rst_n, .flush(1'b0), .in_valid, .in_ready, .in_func, .in_data_byte,
    .q_valid(iq_valid), .q_ready(iq_ready), .q_word(iq_word)
  );

  msh_queue u_queue (
    .clk, .rst_n, .wr_valid(iq_valid), .wr_ready(iq_ready), .wr_word(iq_word),
    .rd_valid(qe_valid), .rd_ready(qe_ready), .rd_word(qe_word)
  );

  msh_engine u_engine (
    .clk, .rst_n, .seed(seed_eff), .restart(cfg_we),
    .w_valid(qe_valid), .w_ready(qe_ready), .w_word(qe_word),
    .out_valid, .out_ready, .out_digest_first, .out_digest_second
  );

  `MSH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready && !cfg_we, out_valid)
  `MSH_ASSERT_NEXT(a_seed_load, clk, rst_n, cfg_we, seed_r == $past(cfg_seed_offset))
  `MSH_ASSERT_IMPL(a_no_take_while_busy, clk, rst_n, qe_ready, !out_valid)
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the streaming MD5 digest block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } byte_word_t;

  typedef struct packed {
    logic [63:0] first;
    logic [63:0] second;
  } digest_t;

  // MD5 step constants and rotate amounts for the digest predictor
  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int MD5_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                4, 11, 16, 23, 6, 10, 15, 21};
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_digest_first;
  logic [63:0] out_digest_second;
  logic        cfg_we;
  logic [31:0] cfg_seed_offset;

  md5_stream_hash_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_first  (out_digest_first),
    .out_digest_second (out_digest_second),
    .cfg_we            (cfg_we),
    .cfg_seed_offset   (cfg_seed_offset)
  );

  // Predictor state
  logic [31:0] pred_seed;
  logic [31:0] pred_chain [4];
  logic [7:0]  pred_block [64];
  logic [63:0] pred_bits;
  logic [5:0]  pred_index;

  byte_word_t  pending_words [$];
  digest_t     expected_digests [$];
  int          error_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;
  bit          timed_out;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [31:0] rot_left(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] swap_bytes(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic void restart_message();
    pred_chain[0] = 32'h67452301 + pred_seed * 32'd11;
    pred_chain[1] = 32'hefcdab89 + pred_seed * 32'd71;
    pred_chain[2] = 32'h98badcfe + pred_seed * 32'd37;
    pred_chain[3] = 32'h10325476 + pred_seed * 32'd97;
    pred_bits = '0;
    pred_index = '0;
  endfunction

  // Run the 64 MD5 steps over the current block and fold into the chain
  function automatic void compress_block(logic [31:0] w14, logic [31:0] w15,
                                         bit use_len);
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g, rnd;
    for (int i = 0; i < 16; i++)
      m[i] = {pred_block[4*i+3], pred_block[4*i+2], pred_block[4*i+1], pred_block[4*i]};
    if (use_len) begin
      m[14] = w14;
      m[15] = w15;
    end
    a = pred_chain[0]; b = pred_chain[1]; c = pred_chain[2]; d = pred_chain[3];
    for (int n = 0; n < 64; n++) begin
      rnd = n / 16;
      case (rnd)
        0: begin f = (b & c) | (~b & d); g = n; end
        1: begin f = (b & d) | (c & ~d); g = (5 * n + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * n + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * n) % 16; end
      endcase
      t = a + f + MD5_K[n] + m[g];
      a = d; d = c; c = b;
      b = b + rot_left(t, MD5_S[rnd * 4 + n % 4]);
    end
    pred_chain[0] += a; pred_chain[1] += b;
    pred_chain[2] += c; pred_chain[3] += d;
  endfunction

  // Advance the predictor by one accepted word; queue a digest on finish
  function automatic void predict_word(byte_word_t w);
    digest_t dg;
    if (w.func == msh_pkg::FUNC_ABSORB) begin
      pred_block[pred_index] = w.data;
      pred_bits += 64'd8;
      pred_index++;
      if (pred_index == 6'd0)
        compress_block('0, '0, 1'b0);
      return;
    end
    pred_block[pred_index] = msh_pkg::PAD_MARK;
    for (int p = int'(pred_index) + 1; p < 64; p++)
      pred_block[p] = 8'h00;
    if (pred_index >= 6'd56) begin
      compress_block('0, '0, 1'b0);
      for (int p = 0; p < 56; p++)
        pred_block[p] = 8'h00;
    end
    compress_block(pred_bits[31:0], pred_bits[63:32], 1'b1);
    dg.first  = {swap_bytes(pred_chain[0]), swap_bytes(pred_chain[1])};
    dg.second = {swap_bytes(pred_chain[2]), swap_bytes(pred_chain[3])};
    expected_digests.push_back(dg);
    restart_message();
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: present the next pending word, hold it until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready)
        predict_word('{func: in_func, data: in_data_byte});
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        byte_word_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_func <= w.func;
        in_data_byte <= w.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each taken digest and toggle receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_digests.size() == 0) begin
          report_mismatch("unexpected digest", out_digest_first, '0);
        end else begin
          digest_t dg;
          dg = expected_digests.pop_front();
          if (out_digest_first !== dg.first)
            report_mismatch("digest_first", out_digest_first, dg.first);
          if (out_digest_second !== dg.second)
            report_mismatch("digest_second", out_digest_second, dg.second);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_word(logic func, logic [7:0] data);
    pending_words.push_back('{func: func, data: data});
  endtask

  task automatic push_message(int len);
    for (int i = 0; i < len; i++)
      push_word(msh_pkg::FUNC_ABSORB, 8'($urandom_range(255)));
    push_word(msh_pkg::FUNC_FINISH, 8'($urandom_range(255)));
  endtask

  // Wait until every word is taken and every digest checked, then settle
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_digests.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_seed_offset <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred_seed = value;
    restart_message();
  endtask

  // Random phase: whole messages only, some of them at padding and block edges
  task automatic random_phase(int words);
    int n;
    n = 0;
    while (n < words) begin
      int len;
      case ($urandom_range(9))
        0: len = 0;
        1: len = 55 + $urandom_range(9);
        2: len = 64 * $urandom_range(1, 2) + $urandom_range(3);
        default: len = $urandom_range(40);
      endcase
      push_message(len);
      n += len + 1;
    end
  endtask

  initial begin
    error_count = 0;
    timed_out = 1'b0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_data_byte = 8'h00;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_seed_offset = 32'h0;
    send_idle_pct = 15;
    recv_idle_pct = 60;
    pred_seed = '0;
    for (int i = 0; i < 64; i++)
      pred_block[i] = 8'h00;
    restart_message();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, extreme bytes, "abc", padding edges
    push_word(msh_pkg::FUNC_FINISH, 8'hff);
    push_word(msh_pkg::FUNC_ABSORB, 8'h00);
    push_word(msh_pkg::FUNC_ABSORB, 8'hff);
    push_word(msh_pkg::FUNC_FINISH, 8'h00);
    push_word(msh_pkg::FUNC_ABSORB, 8'h61);
    push_word(msh_pkg::FUNC_ABSORB, 8'h62);
    push_word(msh_pkg::FUNC_ABSORB, 8'h63);
    push_word(msh_pkg::FUNC_FINISH, 8'h00);
    drain();
    push_message(55);
    push_message(56);
    push_message(63);
    push_message(64);
    drain();

    write_seed(32'hffffffff);
    push_message(3);
    push_word(msh_pkg::FUNC_ABSORB, 8'h5a);
    drain();
    // Seed write abandons the partial message above
    write_seed(32'h1);
    random_phase(160);
    drain();

    send_idle_pct = 60;
    recv_idle_pct = 15;
    write_seed(32'($urandom));
    random_phase(160);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_seed(32'h0);
    random_phase(160);
    drain();

    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/msh_pkg.sv
sv/msh_queue.sv
sv/msh_intake.sv
sv/msh_engine.sv
sv/md5_stream_hash_top.sv
tb/testbench.sv
